// ----- design/pee_pkg.sv -----
package pee_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_STEPS = 32;
    localparam int LEFT_W    = 7;

    // ascii codes of the expression alphabet
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    localparam logic [WORD_W-1:0] DEC_BASE = 32'd10;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } pee_status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_REM
    } pee_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENDNUM,
        S_POPB,
        S_GETB,
        S_GETA,
        S_EXEC,
        S_FPOP,
        S_FGET
    } pee_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } pee_alu_state_t;

    typedef struct packed {
        logic    start;
        pee_op_t op;
    } pee_alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } pee_alu_rsp_t;

endpackage

// ----- design/pee_stack.sv -----
module pee_stack #(
    parameter int STACK_DEPTH = 64,
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [pee_pkg::WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [pee_pkg::WORD_W-1:0] rdata
);

    logic [pee_pkg::WORD_W-1:0] mem [STACK_DEPTH];
    logic [pee_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pee_alu.sv -----
module pee_alu (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pee_pkg::pee_alu_req_t      req,
    input  logic [pee_pkg::WORD_W-1:0] a,
    input  logic [pee_pkg::WORD_W-1:0] b,
    output pee_pkg::pee_alu_rsp_t      rsp,
    output logic [pee_pkg::WORD_W-1:0] result
);

    localparam int W     = pee_pkg::WORD_W;
    localparam int CNT_W = $clog2(pee_pkg::DIV_STEPS);

    pee_pkg::pee_alu_state_t state_reg, state_next;
    logic             done_reg, done_next;
    logic             dz_reg, dz_next;
    logic [W-1:0]     result_reg, result_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             negq_reg, negq_next;
    logic             negr_reg, negr_next;
    logic             isrem_reg, isrem_next;

    logic [W-1:0] abs_a, abs_b;
    logic [W:0]   shifted, trial;

    assign abs_a   = a[W-1] ? (~a + 1'b1) : a;
    assign abs_b   = b[W-1] ? (~b + 1'b1) : b;
    assign shifted = {rem_reg, quot_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        dz_next     = 1'b0;
        result_next = result_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        negq_next   = negq_reg;
        negr_next   = negr_reg;
        isrem_next  = isrem_reg;
        case (state_reg)
            pee_pkg::A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        pee_pkg::OP_ADD:
                        begin
                            result_next = a + b;
                            done_next   = 1'b1;
                        end
                        pee_pkg::OP_SUB:
                        begin
                            result_next = a - b;
                            done_next   = 1'b1;
                        end
                        pee_pkg::OP_MUL:
                        begin
                            result_next = a * b;
                            done_next   = 1'b1;
                        end
                        pee_pkg::OP_DIV, pee_pkg::OP_REM:
                        begin
                            if (b == '0)
                            begin
                                result_next = '0;
                                done_next   = 1'b1;
                                dz_next     = 1'b1;
                            end
                            else
                            begin
                                rem_next   = '0;
                                quot_next  = abs_a;
                                dvs_next   = abs_b;
                                cnt_next   = '0;
                                negq_next  = a[W-1] ^ b[W-1];
                                negr_next  = a[W-1];
                                isrem_next = (req.op == pee_pkg::OP_REM);
                                state_next = pee_pkg::A_DIV;
                            end
                        end
                        default:
                        begin
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            pee_pkg::A_DIV:
            begin
                // restoring step, one quotient bit per cycle
                if (!trial[W])
                begin
                    rem_next  = trial[W-1:0];
                    quot_next = {quot_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted[W-1:0];
                    quot_next = {quot_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pee_pkg::DIV_STEPS - 1))
                begin
                    state_next = pee_pkg::A_FIX;
                end
            end
            pee_pkg::A_FIX:
            begin
                // sign fixup: quotient toward zero, remainder follows dividend
                if (isrem_reg)
                begin
                    result_next = negr_reg ? (~rem_reg + 1'b1) : rem_reg;
                end
                else
                begin
                    result_next = negq_reg ? (~quot_reg + 1'b1) : quot_reg;
                end
                done_next  = 1'b1;
                state_next = pee_pkg::A_IDLE;
            end
            default:
            begin
                state_next = pee_pkg::A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pee_pkg::A_IDLE;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            dz_reg    <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
        negq_reg   <= negq_next;
        negr_reg   <= negr_next;
        isrem_reg  <= isrem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = result_reg;

endmodule

// ----- design/postfix_expression_evaluator_top.sv -----
// Postfix (RPN) expression evaluator, one ascii character per input word. Digits build a
// 32-bit number (wrapping), a comma, an operator or the last word push it; + - * / % pop
// two operands and push "first op second", / and % truncating toward zero. The last word
// produces one output word: the popped result, a sticky status (underflow, overflow,
// divide by zero; first fault kept) and the count of entries left, after which the
// evaluator clears itself. The shared arithmetic unit runs / and % on a 32-step restoring
// divider, one bit per cycle. A last word always closes the pending number first, then
// pops the result, and that final pop waits while the previous output word is still
// stalled. The stack is a single-port-write RAM with a registered read. in_stall is
// high while a word is being worked on.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    input  logic               is_last,
    // output words
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    output logic [6:0]         leftover
);

    localparam int W       = pee_pkg::WORD_W;
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // sticky fault: keep the first one
    function automatic pee_pkg::pee_status_t flag_status(
        input pee_pkg::pee_status_t cur,
        input pee_pkg::pee_status_t code
    );
        flag_status = (cur == pee_pkg::ST_OK) ? code : cur;
    endfunction

    pee_pkg::pee_state_t  state_reg, state_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic                 active_reg, active_next;
    pee_pkg::pee_status_t sticky_reg, sticky_next;
    pee_pkg::pee_op_t     op_reg, op_next;
    logic                 is_op_reg, is_op_next;
    logic                 last_reg, last_next;
    logic [W-1:0]         opb_reg, opb_next;
    logic                 pop_empty_reg, pop_empty_next;
    logic                 out_valid_reg, out_valid_next;
    logic [W-1:0]         value_reg, value_next;
    pee_pkg::pee_status_t status_reg, status_next;
    logic [6:0]           leftover_reg, leftover_next;

    // input decode
    logic             in_digit, in_comma, in_is_op;
    pee_pkg::pee_op_t in_op;

    // stack port
    logic              st_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [W-1:0]      st_wdata, st_rdata;

    // shared arithmetic unit
    pee_pkg::pee_alu_req_t alu_req;
    pee_pkg::pee_alu_rsp_t alu_rsp;
    logic [W-1:0]          alu_a, alu_result;

    logic               full, empty;
    logic [DEPTH_W-1:0] depth_m1;

    assign full     = (depth_reg >= DEPTH_W'(STACK_DEPTH));
    assign empty    = (depth_reg == '0);
    assign depth_m1 = depth_reg - 1'b1;

    always_comb
    begin
        in_digit = character inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]};
        in_comma = (character == pee_pkg::CH_COMMA);
        in_is_op = 1'b1;
        case (character)
            pee_pkg::CH_PLUS:    in_op = pee_pkg::OP_ADD;
            pee_pkg::CH_MINUS:   in_op = pee_pkg::OP_SUB;
            pee_pkg::CH_STAR:    in_op = pee_pkg::OP_MUL;
            pee_pkg::CH_SLASH:   in_op = pee_pkg::OP_DIV;
            pee_pkg::CH_PERCENT: in_op = pee_pkg::OP_REM;
            default:
            begin
                in_op    = pee_pkg::OP_ADD;
                in_is_op = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        acc_next       = acc_reg;
        active_next    = active_reg;
        sticky_next    = sticky_reg;
        op_next        = op_reg;
        is_op_next     = is_op_reg;
        last_next      = last_reg;
        opb_next       = opb_reg;
        pop_empty_next = pop_empty_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        status_next    = status_reg;
        leftover_next  = leftover_reg;
        st_we          = 1'b0;
        st_waddr       = depth_reg[ADDR_W-1:0];
        st_wdata       = acc_reg;
        st_raddr       = depth_m1[ADDR_W-1:0];
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;
        alu_a          = pop_empty_reg ? '0 : st_rdata;
        case (state_reg)
            pee_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = is_last;
                    op_next    = in_op;
                    is_op_next = in_is_op;
                    if (in_digit)
                    begin
                        acc_next    = acc_reg * pee_pkg::DEC_BASE
                                      + {24'd0, character - pee_pkg::CH_ZERO};
                        active_next = 1'b1;
                    end
                    if (in_comma || in_is_op || is_last)
                    begin
                        state_next = pee_pkg::S_ENDNUM;
                    end
                end
            end
            pee_pkg::S_ENDNUM:
            begin
                // close the pending number
                if (active_reg)
                begin
                    if (full)
                    begin
                        sticky_next = flag_status(sticky_reg, pee_pkg::ST_OVER);
                    end
                    else
                    begin
                        st_we      = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                acc_next    = '0;
                active_next = 1'b0;
                if (is_op_reg)
                begin
                    state_next = pee_pkg::S_POPB;
                end
                else if (last_reg)
                begin
                    state_next = pee_pkg::S_FPOP;
                end
                else
                begin
                    state_next = pee_pkg::S_IDLE;
                end
            end
            pee_pkg::S_POPB:
            begin
                if (empty)
                begin
                    sticky_next    = flag_status(sticky_reg, pee_pkg::ST_UNDER);
                    pop_empty_next = 1'b1;
                end
                else
                begin
                    depth_next     = depth_m1;
                    pop_empty_next = 1'b0;
                end
                state_next = pee_pkg::S_GETB;
            end
            pee_pkg::S_GETB:
            begin
                // second operand arrives, first operand read goes out
                opb_next = pop_empty_reg ? '0 : st_rdata;
                if (empty)
                begin
                    sticky_next    = flag_status(sticky_reg, pee_pkg::ST_UNDER);
                    pop_empty_next = 1'b1;
                end
                else
                begin
                    depth_next     = depth_m1;
                    pop_empty_next = 1'b0;
                end
                state_next = pee_pkg::S_GETA;
            end
            pee_pkg::S_GETA:
            begin
                alu_req.start = 1'b1;
                state_next    = pee_pkg::S_EXEC;
            end
            pee_pkg::S_EXEC:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        sticky_next = flag_status(sticky_reg, pee_pkg::ST_DIVZERO);
                    end
                    if (full)
                    begin
                        sticky_next = flag_status(sticky_next, pee_pkg::ST_OVER);
                    end
                    else
                    begin
                        st_we      = 1'b1;
                        st_wdata   = alu_result;
                        depth_next = depth_reg + 1'b1;
                    end
                    state_next = last_reg ? pee_pkg::S_FPOP : pee_pkg::S_IDLE;
                end
            end
            pee_pkg::S_FPOP:
            begin
                if (empty)
                begin
                    sticky_next    = flag_status(sticky_reg, pee_pkg::ST_UNDER);
                    pop_empty_next = 1'b1;
                end
                else
                begin
                    depth_next     = depth_m1;
                    pop_empty_next = 1'b0;
                end
                state_next = pee_pkg::S_FGET;
            end
            pee_pkg::S_FGET:
            begin
                // hold the read address on the popped slot while the output is busy
                st_raddr = depth_reg[ADDR_W-1:0];
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    value_next     = pop_empty_reg ? '0 : st_rdata;
                    status_next    = sticky_reg;
                    leftover_next  = 7'(depth_reg);
                    depth_next     = '0;
                    acc_next       = '0;
                    active_next    = 1'b0;
                    sticky_next    = pee_pkg::ST_OK;
                    state_next     = pee_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pee_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pee_pkg::S_IDLE;
            depth_reg     <= '0;
            acc_reg       <= '0;
            active_reg    <= 1'b0;
            sticky_reg    <= pee_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            acc_reg       <= acc_next;
            active_reg    <= active_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        is_op_reg     <= is_op_next;
        last_reg      <= last_next;
        opb_reg       <= opb_next;
        pop_empty_reg <= pop_empty_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        leftover_reg  <= leftover_next;
    end

    pee_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pee_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (opb_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign in_stall  = (state_reg != pee_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign leftover  = leftover_reg;

    // stack pointer never passes the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth out of range");

    // no pending digits means a clean accumulator
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> acc_reg == '0)
        else $error("accumulator not cleared");

    // the arithmetic unit only answers while the sequencer waits for it
    a_alu_done_exec: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == pee_pkg::S_EXEC)
        else $error("alu result outside execute");

    // a recorded fault holds until the result word is loaded
    a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sticky_reg != pee_pkg::ST_OK && state_reg != pee_pkg::S_FGET)
        |=> sticky_reg == $past(sticky_reg))
        else $error("sticky status lost");

endmodule
